[rtl/motor_throttle_ramp_controller_assert.svh]
// Assertion macros for the throttle ramp controller.
// Used by mtrc_back; needs a clk and rst_n in scope.
`ifndef MOTOR_THROTTLE_RAMP_CONTROLLER_ASSERT_SVH
`define MOTOR_THROTTLE_RAMP_CONTROLLER_ASSERT_SVH

// antecedent holds in a cycle -> consequent holds in the same cycle
`define MTRC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mtrc assertion failed");

// antecedent holds in a cycle -> consequent holds in the next cycle
`define MTRC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mtrc assertion failed");

`endif

[rtl/mtrc_pkg.sv]
// Shared types, constants and helpers for the throttle ramp controller.
// No dependencies.
`default_nettype none

package mtrc_pkg;

    localparam int QDEPTH  = 4;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam int LEVEL_W = 8;
    localparam int STEP_W  = 10;
    localparam int CIDX_W  = 3;

    // bit positions in the packed switch level vector
    localparam int B_START  = 0;
    localparam int B_RRUN   = 1;
    localparam int B_RENA   = 2;
    localparam int B_GEAR1  = 3;
    localparam int B_GEAR2  = 4;
    localparam int B_DIR    = 5;
    localparam int NSW      = 6;

    // register indexes
    localparam logic [CIDX_W-1:0] REG_BOTH_HIGH  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FIRST_LOW  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SECOND_LOW = 3'd2;
    localparam logic [CIDX_W-1:0] REG_STEP_TICKS = 3'd3;

    localparam logic [LEVEL_W-1:0] RST_BOTH_HIGH  = 8'd180;
    localparam logic [LEVEL_W-1:0] RST_FIRST_LOW  = 8'd150;
    localparam logic [LEVEL_W-1:0] RST_SECOND_LOW = 8'd220;
    localparam logic [STEP_W-1:0]  RST_STEP_TICKS = 10'd10;

    typedef struct packed {
        logic [LEVEL_W-1:0] both_high;
        logic [LEVEL_W-1:0] first_low;
        logic [LEVEL_W-1:0] second_low;
        logic [STEP_W-1:0]  step_ticks;
    } cfg_t;

    typedef struct packed {
        logic           first;
        logic [NSW-1:0] levels;
    } tick_t;

    typedef struct packed {
        logic  valid;
        tick_t item;
    } q_rd_t;

    function automatic logic [LEVEL_W-1:0] gear_level_of(input cfg_t cfg,
                                                         input logic g1,
                                                         input logic g2);
        logic [LEVEL_W-1:0] lvl;
        case ({g1, g2})
            2'b11:   lvl = cfg.both_high;
            2'b01:   lvl = cfg.first_low;
            2'b10:   lvl = cfg.second_low;
            default: lvl = '0;
        endcase
        return lvl;
    endfunction

endpackage

`default_nettype wire

[rtl/mtrc_front.sv]
// Input side: takes tick transfers, packs the switch levels and tags the first tick.
// Depends on mtrc_pkg.
`default_nettype none

module mtrc_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire logic          start_sw,
    input  wire logic          remote_run_sw,
    input  wire logic          remote_enable_sw,
    input  wire logic          gear_sw1,
    input  wire logic          gear_sw2,
    input  wire logic          dir_sw,
    input  wire logic          q_full,
    output logic               q_push,
    output mtrc_pkg::tick_t    q_item
);
    import mtrc_pkg::*;

    logic first_pending_reg;
    logic first_pending_next;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_item.first          = first_pending_reg;
        q_item.levels[B_START] = start_sw;
        q_item.levels[B_RRUN]  = remote_run_sw;
        q_item.levels[B_RENA]  = remote_enable_sw;
        q_item.levels[B_GEAR1] = gear_sw1;
        q_item.levels[B_GEAR2] = gear_sw2;
        q_item.levels[B_DIR]   = dir_sw;
    end

    assign first_pending_next = q_push ? 1'b0 : first_pending_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_pending_reg <= 1'b1;
        end
        else
        begin
            first_pending_reg <= first_pending_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mtrc_queue.sv]
// Short tick queue between the input side and the control core.
// Depends on mtrc_pkg.
`default_nettype none

module mtrc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mtrc_pkg::tick_t push_item,
    output logic                full,
    input  wire logic           pop,
    output mtrc_pkg::q_rd_t     rd
);
    import mtrc_pkg::*;

    tick_t             mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign full     = (count_reg == QCNT_W'(QDEPTH));
    assign rd.valid = (count_reg != '0);
    assign rd.item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/mtrc_back.sv]
// Control core: edge handling, throttle ramp and the result register.
// Depends on mtrc_pkg and motor_throttle_ramp_controller_assert.svh.
`default_nettype none
`include "motor_throttle_ramp_controller_assert.svh"

module mtrc_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire mtrc_pkg::cfg_t  cfg,
    input  wire mtrc_pkg::q_rd_t rd,
    output logic                 pop,
    output logic                 out_valid,
    input  wire logic            out_stall,
    output logic [7:0]           throttle_pwm,
    output logic                 brake_on,
    output logic                 direction_out,
    output logic                 relay_drive,
    output logic                 ramping
);
    import mtrc_pkg::*;

    logic [NSW-1:0]     prev_reg,  prev_next;
    logic [LEVEL_W-1:0] gear_reg,  gear_next;
    logic [LEVEL_W-1:0] pwm_reg,   pwm_next;
    logic [LEVEL_W-1:0] goal_reg,  goal_next;
    logic [STEP_W-1:0]  count_reg, count_next;
    logic               brake_reg, brake_next;
    logic               dir_reg,   dir_next;
    logic               armed_reg, armed_next;
    logic               used_reg,  used_next;
    logic               relay_reg, relay_next;
    logic               ovalid_reg, ovalid_next;

    logic [NSW-1:0]     lv;
    logic [NSW-1:0]     ch;
    logic [STEP_W-1:0]  lim;
    logic [LEVEL_W-1:0] sw_level;
    logic               st, rr, re;

    // state registers double as the result register: they only move on a pop
    assign pop = rd.valid && (!ovalid_reg || !out_stall);

    assign lv  = rd.item.levels;
    assign ch  = lv ^ prev_reg;
    assign st  = lv[B_START];
    assign rr  = lv[B_RRUN];
    assign re  = lv[B_RENA];
    assign lim = (cfg.step_ticks == '0) ? STEP_W'(1) : cfg.step_ticks;
    assign sw_level = gear_level_of(cfg, lv[B_GEAR1], lv[B_GEAR2]);

    always_comb
    begin
        prev_next  = prev_reg;
        gear_next  = gear_reg;
        pwm_next   = pwm_reg;
        goal_next  = goal_reg;
        count_next = count_reg;
        brake_next = brake_reg;
        dir_next   = dir_reg;
        armed_next = armed_reg;
        used_next  = used_reg;
        relay_next = relay_reg;
        ovalid_next = pop ? 1'b1 : (ovalid_reg && out_stall);

        if (pop)
        begin
            if (rd.item.first)
            begin
                prev_next  = lv;
                dir_next   = lv[B_DIR];
                armed_next = st;
            end
            else if (pwm_reg != goal_reg)
            begin
                // ramp in progress: edges wait, prev levels are kept
                count_next = count_reg + STEP_W'(1);
                if (count_next >= lim)
                begin
                    count_next = '0;
                    pwm_next = (pwm_reg < goal_reg) ? pwm_reg + LEVEL_W'(1)
                                                    : pwm_reg - LEVEL_W'(1);
                end
            end
            else
            begin
                prev_next = lv;
                // gear change
                if (ch[B_GEAR1] || ch[B_GEAR2])
                begin
                    if ((!st || !rr) && (sw_level != gear_reg))
                    begin
                        pwm_next   = gear_reg;
                        goal_next  = sw_level;
                        count_next = '0;
                    end
                    gear_next = sw_level;
                end
                // local start
                if (ch[B_START])
                begin
                    if (!st && armed_reg && re)
                    begin
                        brake_next = 1'b0;
                        gear_next  = sw_level;
                        pwm_next   = '0;
                        goal_next  = sw_level;
                        count_next = '0;
                    end
                    if (st)
                    begin
                        armed_next = 1'b1;
                        brake_next = 1'b1;
                        pwm_next   = '0;
                        goal_next  = '0;
                        count_next = '0;
                        gear_next  = '0;
                    end
                end
                // remote enable
                if (ch[B_RENA])
                begin
                    relay_next = re;
                end
                // remote run
                if (ch[B_RRUN])
                begin
                    pwm_next   = '0;
                    count_next = '0;
                    if (!rr)
                    begin
                        used_next  = 1'b1;
                        brake_next = 1'b0;
                        gear_next  = sw_level;
                        goal_next  = sw_level;
                    end
                    else
                    begin
                        brake_next = 1'b1;
                        goal_next  = '0;
                        gear_next  = '0;
                    end
                end
                // direction: one toggle, stop first when running
                if (ch[B_DIR])
                begin
                    if ((!st && !used_next) || !rr)
                    begin
                        pwm_next   = '0;
                        goal_next  = '0;
                        count_next = '0;
                        brake_next = 1'b0;
                    end
                    dir_next = !dir_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg   <= '0;
            gear_reg   <= '0;
            pwm_reg    <= '0;
            goal_reg   <= '0;
            count_reg  <= '0;
            brake_reg  <= 1'b1;
            dir_reg    <= 1'b0;
            armed_reg  <= 1'b0;
            used_reg   <= 1'b0;
            relay_reg  <= 1'b1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            prev_reg   <= prev_next;
            gear_reg   <= gear_next;
            pwm_reg    <= pwm_next;
            goal_reg   <= goal_next;
            count_reg  <= count_next;
            brake_reg  <= brake_next;
            dir_reg    <= dir_next;
            armed_reg  <= armed_next;
            used_reg   <= used_next;
            relay_reg  <= relay_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign out_valid     = ovalid_reg;
    assign throttle_pwm  = pwm_reg;
    assign brake_on      = brake_reg;
    assign direction_out = !dir_reg;
    assign relay_drive   = relay_reg;
    assign ramping       = (pwm_reg != goal_reg);

    // a held result must not be overwritten by a new tick
    `MTRC_ASSERT_NOW(a_no_pop_while_held, ovalid_reg && out_stall, !pop)
    // ticks during a ramp leave the edge reference alone
    `MTRC_ASSERT_NEXT(a_prev_kept_in_ramp, pop && !rd.item.first && (pwm_reg != goal_reg),
        $stable(prev_reg))
    // a ramp tick moves the throttle by at most one unit
    `MTRC_ASSERT_NEXT(a_ramp_one_unit, pop && !rd.item.first && (pwm_reg != goal_reg),
        (pwm_reg == $past(pwm_reg)) || (pwm_reg == $past(pwm_reg) + 8'd1) ||
        (pwm_reg == $past(pwm_reg) - 8'd1))
    // state is frozen while no tick is taken
    `MTRC_ASSERT_NEXT(a_idle_frozen, !pop, $stable(pwm_reg) && $stable(dir_reg))

endmodule

`default_nettype wire

[rtl/motor_throttle_ramp_controller.sv]
// Top level of the motor throttle ramp controller: config registers and the
// front / queue / core chain. Depends on mtrc_pkg, mtrc_front, mtrc_queue, mtrc_back.
//
// Usage:
//  - Tick channel (in_valid / in_stall): one transfer per tick carrying the six
//    debounced switch levels. in_stall rises only when the four-entry tick
//    queue is full, i.e. when the result side has been stalled for a while.
//  - Result channel (out_valid / out_stall): one result per tick with the
//    throttle duty, brake, direction, relay and ramping flag. The core's
//    state registers are the result register: a result is registered when
//    the core pops its tick off the queue, and can be taken at the next edge.
//  - Throughput: one tick per cycle while out_stall stays low. The per-tick
//    work in the core is one ramp counter step or one edge priority chain pass.
//  - Config (cfg_valid / cfg_ready, cfg_index, cfg_data): cfg_ready is always
//    high; indexes 0..2 set the gear levels (low 8 data bits), 3 sets the ramp
//    step tick count (0 acts as 1). Other indexes are ignored. Write only
//    while idle.
//  - Reset (rst_n low, async): queue empty, brake on, relay drive high,
//    throttle 0, config back to 180 / 150 / 220 / 10. The first tick after
//    reset only latches the switch levels, direction and armed flag.
//  - When out_stall is high the core holds its result and stops draining
//    the queue; ticks keep landing in the queue until it fills.
`default_nettype none

module motor_throttle_ramp_controller (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           start_sw,
    input  wire logic                           remote_run_sw,
    input  wire logic                           remote_enable_sw,
    input  wire logic                           gear_sw1,
    input  wire logic                           gear_sw2,
    input  wire logic                           dir_sw,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [7:0]                          throttle_pwm,
    output logic                                brake_on,
    output logic                                direction_out,
    output logic                                relay_drive,
    output logic                                ramping,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [mtrc_pkg::CIDX_W-1:0]    cfg_index,
    input  wire logic [mtrc_pkg::STEP_W-1:0]    cfg_data
);
    import mtrc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    tick_t q_item;
    q_rd_t q_rd;
    logic  q_push, q_full, q_pop;

    assign cfg_ready = 1'b1;

    // register file: one transfer writes one register
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_BOTH_HIGH:  cfg_next.both_high  = cfg_data[LEVEL_W-1:0];
                REG_FIRST_LOW:  cfg_next.first_low  = cfg_data[LEVEL_W-1:0];
                REG_SECOND_LOW: cfg_next.second_low = cfg_data[LEVEL_W-1:0];
                REG_STEP_TICKS: cfg_next.step_ticks = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.both_high  <= RST_BOTH_HIGH;
            cfg_reg.first_low  <= RST_FIRST_LOW;
            cfg_reg.second_low <= RST_SECOND_LOW;
            cfg_reg.step_ticks <= RST_STEP_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mtrc_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_sw         (start_sw),
        .remote_run_sw    (remote_run_sw),
        .remote_enable_sw (remote_enable_sw),
        .gear_sw1         (gear_sw1),
        .gear_sw2         (gear_sw2),
        .dir_sw           (dir_sw),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_item           (q_item)
    );

    mtrc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .rd        (q_rd)
    );

    mtrc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .rd            (q_rd),
        .pop           (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .throttle_pwm  (throttle_pwm),
        .brake_on      (brake_on),
        .direction_out (direction_out),
        .relay_drive   (relay_drive),
        .ramping       (ramping)
    );

endmodule

`default_nettype wire

[tb/motor_throttle_ramp_controller_tb.sv]
// Self-checking testbench for motor_throttle_ramp_controller.
// Needs mtrc_pkg and the controller RTL; keeps a cycle-free model of the
// controller state and checks every result transfer against it.
`timescale 1ns / 1ps

module motor_throttle_ramp_controller_tb;
    import mtrc_pkg::*;

    // ------------------------------------------------------------------
    // Local types and constants
    // ------------------------------------------------------------------
    typedef logic [NSW-1:0] sw_t;

    // one result transfer, field by field
    typedef struct packed {
        logic [LEVEL_W-1:0] pwm;
        logic               brake;
        logic               dir_out;
        logic               relay;
        logic               ramp;
    } ctrl_out_t;

    // single-switch masks in the packed level vector
    localparam sw_t M_START = sw_t'(1) << B_START;
    localparam sw_t M_RRUN  = sw_t'(1) << B_RRUN;
    localparam sw_t M_RENA  = sw_t'(1) << B_RENA;
    localparam sw_t M_GEAR1 = sw_t'(1) << B_GEAR1;
    localparam sw_t M_GEAR2 = sw_t'(1) << B_GEAR2;
    localparam sw_t M_DIR   = sw_t'(1) << B_DIR;

    localparam int LONG_HOLD    = 64;    // receiver hold-off in the pressure test
    localparam int STALL_LIMIT  = 3000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 8;     // quiet cycles after the last result
    localparam int PRINT_CAP    = 40;    // mismatch lines printed at most

    // ------------------------------------------------------------------
    // DUT connections; every input has a known value from time zero
    // ------------------------------------------------------------------
    logic                clk              = 1'b0;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_stall;
    logic                start_sw         = 1'b1;
    logic                remote_run_sw    = 1'b1;
    logic                remote_enable_sw = 1'b1;
    logic                gear_sw1         = 1'b0;
    logic                gear_sw2         = 1'b0;
    logic                dir_sw           = 1'b0;
    logic                out_valid;
    logic                out_stall        = 1'b0;
    logic [7:0]          throttle_pwm;
    logic                brake_on;
    logic                direction_out;
    logic                relay_drive;
    logic                ramping;
    logic                cfg_valid        = 1'b0;
    logic                cfg_ready;
    logic [CIDX_W-1:0]   cfg_index        = '0;
    logic [STEP_W-1:0]   cfg_data         = '0;

    motor_throttle_ramp_controller dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .start_sw         (start_sw),
        .remote_run_sw    (remote_run_sw),
        .remote_enable_sw (remote_enable_sw),
        .gear_sw1         (gear_sw1),
        .gear_sw2         (gear_sw2),
        .dir_sw           (dir_sw),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .throttle_pwm     (throttle_pwm),
        .brake_on         (brake_on),
        .direction_out    (direction_out),
        .relay_drive      (relay_drive),
        .ramping          (ramping),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    // 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Controller model: config copy and state, starting from reset values
    // ------------------------------------------------------------------
    logic [LEVEL_W-1:0] lvl_both_high   = RST_BOTH_HIGH;
    logic [LEVEL_W-1:0] lvl_first_low   = RST_FIRST_LOW;
    logic [LEVEL_W-1:0] lvl_second_low  = RST_SECOND_LOW;
    logic [STEP_W-1:0]  step_ticks      = RST_STEP_TICKS;

    sw_t                sw_prev         = '0;
    logic               seen_first      = 1'b0;
    logic [LEVEL_W-1:0] gear_lvl        = '0;
    logic [LEVEL_W-1:0] duty            = '0;
    logic [LEVEL_W-1:0] duty_goal       = '0;
    logic [STEP_W-1:0]  step_cnt        = '0;
    logic               brake           = 1'b1;
    logic               dir_st          = 1'b0;
    logic               armed           = 1'b0;
    logic               remote_used     = 1'b0;
    logic               relay           = 1'b1;

    // predicted results waiting for their transfer, oldest first
    ctrl_out_t          drive_outputs_due[$];

    // stimulus and bookkeeping
    sw_t    sw_now         = '0;
    int     send_idle_pct  = 0;
    int     recv_idle_pct  = 0;
    int     hold_req       = 0;   // bumped by a test to ask for a long hold-off
    int     hold_served    = 0;
    int     hold_left      = 0;
    int     mismatches     = 0;
    int     ticks_sent     = 0;
    int     results_seen   = 0;
    int     cfg_writes     = 0;
    int     quiet_cycles   = 0;
    int     in_stall_run   = 0;
    int     in_stall_max   = 0;

    function automatic logic [LEVEL_W-1:0] gear_target(input logic g1, input logic g2);
        case ({g1, g2})
            2'b11:   return lvl_both_high;
            2'b01:   return lvl_first_low;
            2'b10:   return lvl_second_low;
            default: return '0;   // both low selects no throttle
        endcase
    endfunction

    function automatic void start_ramp(input logic [LEVEL_W-1:0] from,
                                       input logic [LEVEL_W-1:0] to);
        duty      = from;
        duty_goal = to;
        step_cnt  = '0;
    endfunction

    // One tick through the model; returns the result it must produce.
    function automatic ctrl_out_t advance_controller(input sw_t lv);
        sw_t                changed;
        logic [LEVEL_W-1:0] new_lvl;
        logic               st, rr, re, g1, g2, ds;
        ctrl_out_t          r;
        st = lv[B_START];
        rr = lv[B_RRUN];
        re = lv[B_RENA];
        g1 = lv[B_GEAR1];
        g2 = lv[B_GEAR2];
        ds = lv[B_DIR];
        if (!seen_first)
        begin
            // first tick only latches
            seen_first = 1'b1;
            sw_prev    = lv;
            dir_st     = ds;
            armed      = st;
        end
        else if (duty != duty_goal)
        begin
            // ramp running: edges stay pending, sw_prev untouched
            step_cnt = step_cnt + 1'b1;
            if (step_cnt >= ((step_ticks == '0) ? STEP_W'(1) : step_ticks))
            begin
                step_cnt = '0;
                duty     = (duty < duty_goal) ? duty + 1'b1 : duty - 1'b1;
            end
        end
        else
        begin
            changed = lv ^ sw_prev;
            sw_prev = lv;
            if (changed[B_GEAR1] || changed[B_GEAR2])
            begin
                new_lvl = gear_target(g1, g2);
                if ((!st || !rr) && new_lvl != gear_lvl)
                    start_ramp(gear_lvl, new_lvl);
                gear_lvl = new_lvl;
            end
            if (changed[B_START])
            begin
                if (!st && armed && re)
                begin
                    brake    = 1'b0;
                    gear_lvl = gear_target(g1, g2);
                    start_ramp('0, gear_lvl);
                end
                if (st)
                begin
                    armed    = 1'b1;
                    brake    = 1'b1;
                    start_ramp('0, '0);
                    gear_lvl = '0;
                end
            end
            if (changed[B_RENA])
                relay = re;
            if (changed[B_RRUN])
            begin
                if (!rr)
                begin
                    remote_used = 1'b1;
                    brake       = 1'b0;
                    gear_lvl    = gear_target(g1, g2);
                    start_ramp('0, gear_lvl);
                end
                else
                begin
                    brake    = 1'b1;
                    start_ramp('0, '0);
                    gear_lvl = '0;
                end
            end
            if (changed[B_DIR])
            begin
                // one chain: the toggle happens exactly once
                if ((!st && !remote_used) || !rr)
                begin
                    start_ramp('0, '0);
                    brake = 1'b0;
                end
                dir_st = ~dir_st;
            end
        end
        r.pwm     = duty;
        r.brake   = brake;
        r.dir_out = ~dir_st;
        r.relay   = relay;
        r.ramp    = (duty != duty_goal);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Tick channel: drive at negedge, transfer seen at posedge
    // ------------------------------------------------------------------
    task automatic apply_tick(input sw_t lv);
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid         <= 1'b1;
        start_sw         <= lv[B_START];
        remote_run_sw    <= lv[B_RRUN];
        remote_enable_sw <= lv[B_RENA];
        gear_sw1         <= lv[B_GEAR1];
        gear_sw2         <= lv[B_GEAR2];
        dir_sw           <= lv[B_DIR];
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        drive_outputs_due.push_back(advance_controller(lv));
        ticks_sent++;
    endtask

    // An edge, then steady ticks until the ramp it caused has ended.
    task automatic tick_and_settle(input sw_t lv);
        sw_now = lv;
        apply_tick(lv);
        while (duty != duty_goal)
            apply_tick(lv);
    endtask

    // Drop valid and wait until every predicted result has been taken.
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (drive_outputs_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes all four registers while the block is idle. Level registers get
    // random junk above bit 7, which the block must drop.
    task automatic load_config(input logic [LEVEL_W-1:0] both_high,
                               input logic [LEVEL_W-1:0] first_low,
                               input logic [LEVEL_W-1:0] second_low,
                               input logic [STEP_W-1:0]  ticks);
        logic [STEP_W-1:0] vals [4];
        drain_results();
        vals[REG_BOTH_HIGH]  = {2'($urandom_range(3)), both_high};
        vals[REG_FIRST_LOW]  = {2'($urandom_range(3)), first_low};
        vals[REG_SECOND_LOW] = {2'($urandom_range(3)), second_low};
        vals[REG_STEP_TICKS] = ticks;
        for (int i = 0; i < 4; i++)
        begin
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_index <= CIDX_W'(i);
            cfg_data  <= vals[i];
            do
                @(posedge clk);
            while (cfg_ready !== 1'b1);
            case (CIDX_W'(i))
                REG_BOTH_HIGH:  lvl_both_high  = vals[i][LEVEL_W-1:0];
                REG_FIRST_LOW:  lvl_first_low  = vals[i][LEVEL_W-1:0];
                REG_SECOND_LOW: lvl_second_low = vals[i][LEVEL_W-1:0];
                REG_STEP_TICKS: step_ticks     = vals[i];
                default: ;
            endcase
            cfg_writes++;
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random ticks: mostly held levels so ramps can finish and deferred edges
    // get handled, with single and double switch flips and some full noise.
    task automatic run_random(input int n, input int send_pct, input int recv_pct);
        int pick;
        int idx;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        repeat (n)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                sw_now = sw_t'($urandom);
            else if (pick < 24)
            begin
                idx = $urandom_range(NSW-1);
                sw_now[idx] = ~sw_now[idx];
                if (pick >= 20)
                begin
                    idx = $urandom_range(NSW-1);
                    sw_now[idx] = ~sw_now[idx];
                end
            end
            apply_tick(sw_now);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    // A hold-off request from a test wins over the random stall pattern.
    always @(negedge clk)
    begin
        if (hold_req != hold_served)
        begin
            hold_served++;
            hold_left = LONG_HOLD;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= PRINT_CAP)
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        ctrl_out_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            results_seen++;
            if (drive_outputs_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= PRINT_CAP)
                    $display("%0t ns: result transfer with nothing expected", $time);
            end
            else
            begin
                want = drive_outputs_due.pop_front();
                check_field("throttle_pwm",  want.pwm,         throttle_pwm);
                check_field("brake_on",      8'(want.brake),   8'(brake_on));
                check_field("direction_out", 8'(want.dir_out), 8'(direction_out));
                check_field("relay_drive",   8'(want.relay),   8'(relay_drive));
                check_field("ramping",       8'(want.ramp),    8'(ramping));
            end
        end
    end

    // Watchdog: any transfer on any channel resets the quiet count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (in_valid && in_stall)
            begin
                in_stall_run++;
                if (in_stall_run > in_stall_max)
                    in_stall_max = in_stall_run;
            end
            else
                in_stall_run = 0;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
                         $time, quiet_cycles, drive_outputs_due.size());
                $display("motor_throttle_ramp_controller_tb: FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset config: first tick latches (start released -> armed), a start
    // press with both gear switches low, then a gear edge while running that
    // starts a slow ramp at the reset step count.
    task automatic test_reset_values();
        send_idle_pct = 8;
        recv_idle_pct = 80;
        sw_now = M_START | M_RRUN | M_RENA;
        apply_tick(sw_now);
        sw_now ^= M_START;
        apply_tick(sw_now);
        sw_now ^= M_GEAR1 | M_GEAR2;
        apply_tick(sw_now);
        repeat (12) apply_tick(sw_now);
    endtask

    // Every edge kind and branch, each followed by steady ticks until idle.
    task automatic test_directed();
        load_config(8'd6, 8'd3, 8'd9, 10'd1);
        tick_and_settle(sw_now);                     // finish the reset-config ramp
        tick_and_settle(sw_now ^ M_DIR);             // dir, local run, remote unused
        tick_and_settle(sw_now ^ M_START);           // release: armed, brake on
        tick_and_settle(sw_now ^ M_RENA);            // remote enabled -> relay low
        tick_and_settle(sw_now ^ M_START);           // press ignored while remote on
        tick_and_settle(sw_now ^ M_DIR);             // dir with start held low
        tick_and_settle(sw_now ^ M_START);
        tick_and_settle(sw_now ^ M_RENA);            // relay back high
        tick_and_settle(sw_now ^ M_GEAR1);           // gear change, motor stopped
        tick_and_settle(sw_now ^ M_START);           // armed press ramps up
        tick_and_settle(sw_now ^ M_GEAR1 ^ M_GEAR2); // gear change while running
        tick_and_settle(sw_now ^ M_GEAR1);           // both low ramps to zero
        tick_and_settle(sw_now ^ M_START);
        tick_and_settle(sw_now ^ M_RRUN);            // remote run
        tick_and_settle(sw_now ^ M_GEAR1 ^ M_GEAR2); // ramp under remote run
        tick_and_settle(sw_now ^ M_DIR);             // dir under remote run
        tick_and_settle(sw_now ^ M_RRUN);            // remote stop
        tick_and_settle(sw_now ^ M_START ^ M_DIR);   // press + dir, remote used
        tick_and_settle(sw_now ^ M_GEAR2 ^ M_RRUN);  // remote run overrides gear ramp
        tick_and_settle(~sw_now);                    // every switch at once
    endtask

    task automatic test_random_wide();
        load_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 10'd1);
        run_random(60, 8, 80);
    endtask

    task automatic test_random_fine();
        load_config(8'($urandom_range(20)), 8'($urandom_range(20)),
                    8'($urandom_range(20)), 10'($urandom_range(3, 1)));
        run_random(80, 80, 8);
    endtask

    task automatic test_random_free();
        load_config(8'($urandom_range(12)), 8'($urandom_range(12)),
                    8'($urandom_range(12)), 10'($urandom_range(2, 1)));
        run_random(80, 0, 0);
    endtask

    // Extreme settings: the longest step count (long enough for one step to
    // land), then a zero step count, which must behave like one.
    task automatic test_extremes();
        load_config(8'd255, 8'd0, 8'd1, 10'd1023);
        run_random(1050, 0, 0);
        load_config(8'd0, 8'd255, 8'd3, 10'd0);
        run_random(60, 0, 0);
    endtask

    // Receiver holds off for a long stretch while ticks keep coming, so the
    // tick queue fills and in_stall must rise with no transfer lost.
    task automatic test_backpressure();
        load_config(8'($urandom_range(8)), 8'($urandom_range(8)),
                    8'($urandom_range(8)), 10'd1);
        hold_req++;
        run_random(80, 0, 0);
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_values();
        test_directed();
        test_random_wide();
        test_random_fine();
        test_random_free();
        test_extremes();
        test_backpressure();

        drain_results();
        $display("covered %0d ticks and %0d result transfers over %0d register writes",
                 ticks_sent, results_seen, cfg_writes);
        $display("longest tick-side stall %0d cycles, %0d mismatches",
                 in_stall_max, mismatches);
        if (mismatches == 0)
            $display("motor_throttle_ramp_controller_tb: PASS");
        else
            $display("motor_throttle_ramp_controller_tb: FAIL");
        $finish;
    end

endmodule
